### rtl/spq_pkg.sv
// Shared types and constants for the stable priority queue.
// Used by spq_ctrl, spq_datapath and stable_priority_queue; depends on nothing.

package spq_pkg;

   // Queue size and priority range. The result fields have fixed widths,
   // so these stay fixed too.
   localparam int DEPTH       = 16;
   localparam int PRIO_LEVELS = 5;

   localparam int PRIO_W = 3;
   localparam int ID_W   = 31;
   localparam int CNT_W  = 5;

   // Stream widths; the tdata widths are padded to whole bytes.
   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;
   localparam int RSP_TUSER_W = 3;

   // Request kinds.
   localparam logic OP_ENQUEUE = 1'b0;
   localparam logic OP_DEQUEUE = 1'b1;

   typedef enum logic [1:0] {
      STAT_DONE  = 2'd0,
      STAT_FULL  = 2'd1,
      STAT_EMPTY = 2'd2
   } status_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic load;   // Capture the accepted request.
      logic exec;   // Update the slots and load the response register.
   } cmd_type;

endpackage

### rtl/spq_ctrl.sv
// Controller for the stable priority queue: request and response handshakes.
// Depends on spq_pkg; drives the command struct of spq_datapath.

module spq_ctrl (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_tvalid,
   output logic             req_tready,
   output logic             rsp_tvalid,
   input  logic             rsp_tready,
   output spq_pkg::cmd_type cmd
);

   typedef enum logic {
      ST_IDLE,
      ST_WORK
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign out_free   = !rsp_valid_ff || rsp_tready;

   always_comb begin
      state_in     = state_ff;
      cmd.load     = 1'b0;
      cmd.exec     = 1'b0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.load = 1'b1;
               state_in = ST_WORK;
            end
         end
         ST_WORK: begin
            // The response register must be free or draining this cycle.
            if (out_free) begin
               cmd.exec     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/spq_datapath.sv
// Datapath for the stable priority queue: request register, sorted shift-register
// slots, fill count and response register. Depends on spq_pkg; driven by spq_ctrl.

module spq_datapath (
   input  logic                                clock,
   input  logic                                reset,
   input  spq_pkg::cmd_type                    cmd,
   input  logic [spq_pkg::REQ_TDATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   output logic [spq_pkg::RSP_TDATA_W-1:0]     rsp_tdata,
   output logic [spq_pkg::RSP_TUSER_W-1:0]     rsp_tuser
);

   localparam int DEPTH  = spq_pkg::DEPTH;
   localparam int PRIO_W = spq_pkg::PRIO_W;
   localparam int ID_W   = spq_pkg::ID_W;
   localparam int CNT_W  = spq_pkg::CNT_W;

   logic                op_ff;
   logic [PRIO_W-1:0]   prio_ff;
   logic [ID_W-1:0]     id_ff;

   logic [PRIO_W-1:0]   slot_prio_ff [DEPTH];
   logic [ID_W-1:0]     slot_id_ff   [DEPTH];
   logic [PRIO_W-1:0]   slot_prio_in [DEPTH];
   logic [ID_W-1:0]     slot_id_in   [DEPTH];
   logic [PRIO_W-1:0]   prev_prio    [DEPTH];
   logic [ID_W-1:0]     prev_id      [DEPTH];
   logic [DEPTH-1:0]    keep;
   logic [DEPTH-1:0]    keep_prev;

   logic [CNT_W-1:0]    count_ff, count_in;
   logic [PRIO_W-1:0]   prio_sat;
   logic                full, empty;

   logic                out_valid;
   logic [PRIO_W-1:0]   out_prio;
   logic [ID_W-1:0]     out_id;
   spq_pkg::status_type status;

   logic [spq_pkg::RSP_TDATA_W-1:0] rsp_tdata_ff;
   logic [spq_pkg::RSP_TUSER_W-1:0] rsp_tuser_ff;

   assign full  = (count_ff == CNT_W'(DEPTH));
   assign empty = (count_ff == '0);

   assign prio_sat = (prio_ff >= PRIO_W'(spq_pkg::PRIO_LEVELS))
                     ? PRIO_W'(spq_pkg::PRIO_LEVELS - 1) : prio_ff;

   // A slot keeps its entry when it is occupied and at least as urgent as (value
   // no greater than) the new entry; since slots are sorted these form a prefix.
   always_comb begin
      for (int k = 0; k < DEPTH; k++) begin
         keep[k] = (CNT_W'(k) < count_ff) && (slot_prio_ff[k] <= prio_sat);
      end
      keep_prev[0] = 1'b1;
      prev_prio[0] = prio_sat;
      prev_id[0]   = id_ff;
      for (int k = 1; k < DEPTH; k++) begin
         keep_prev[k] = keep[k-1];
         prev_prio[k] = slot_prio_ff[k-1];
         prev_id[k]   = slot_id_ff[k-1];
      end
   end

   always_comb begin
      count_in  = count_ff;
      out_valid = 1'b0;
      out_prio  = '0;
      out_id    = '0;
      status    = spq_pkg::STAT_DONE;
      for (int k = 0; k < DEPTH; k++) begin
         slot_prio_in[k] = slot_prio_ff[k];
         slot_id_in[k]   = slot_id_ff[k];
      end
      if (op_ff == spq_pkg::OP_ENQUEUE) begin
         if (full) begin
            status = spq_pkg::STAT_FULL;
         end else begin
            count_in = count_ff + CNT_W'(1);
            for (int k = 0; k < DEPTH; k++) begin
               if (!keep[k]) begin
                  // The first slot past the kept prefix takes the new entry;
                  // the ones after it take their left neighbor.
                  if (keep_prev[k]) begin
                     slot_prio_in[k] = prio_sat;
                     slot_id_in[k]   = id_ff;
                  end else begin
                     slot_prio_in[k] = prev_prio[k];
                     slot_id_in[k]   = prev_id[k];
                  end
               end
            end
         end
      end else begin
         if (empty) begin
            status = spq_pkg::STAT_EMPTY;
         end else begin
            count_in  = count_ff - CNT_W'(1);
            out_valid = 1'b1;
            out_prio  = slot_prio_ff[0];
            out_id    = slot_id_ff[0];
            for (int k = 0; k < DEPTH - 1; k++) begin
               slot_prio_in[k] = slot_prio_ff[k+1];
               slot_id_in[k]   = slot_id_ff[k+1];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         op_ff   <= req_tuser;
         prio_ff <= req_tdata[PRIO_W-1:0];
         id_ff   <= req_tdata[PRIO_W+ID_W-1:PRIO_W];
      end
      if (cmd.exec) begin
         for (int k = 0; k < DEPTH; k++) begin
            slot_prio_ff[k] <= slot_prio_in[k];
            slot_id_ff[k]   <= slot_id_in[k];
         end
         rsp_tdata_ff <= {count_in, (count_in == '0), out_id, out_prio};
         rsp_tuser_ff <= {status, out_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (cmd.exec) begin
         count_ff <= count_in;
      end
   end

   assign rsp_tdata = rsp_tdata_ff;
   assign rsp_tuser = rsp_tuser_ff;

endmodule

### rtl/stable_priority_queue.sv
// Top level of the stable priority queue: controller plus datapath.
// Depends on spq_pkg, spq_ctrl and spq_datapath.
//
//  Group   Direction  Payload
//  req_    in         tuser: opcode; tdata: priority_req, entry_id
//  rsp_    out        tuser: out_valid, status; tdata: out_priority, out_id, empty_res, count
//
// One request at a time: it is captured (ST_IDLE), then executed (ST_WORK) by
// comparing all slots in parallel and shifting the sorted slot registers. The
// response register holds a result until taken; execution waits for it to drain.
// Reset clears the fill count and the handshake state; slot contents are not reset.

module stable_priority_queue (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [spq_pkg::REQ_TDATA_W-1:0]   req_tdata,  // [2:0] priority_req, [33:3] entry_id
   input  logic                              req_tuser,  // [0] opcode
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [spq_pkg::RSP_TDATA_W-1:0]   rsp_tdata,  // [2:0] out_priority, [33:3] out_id,
                                                         // [34] empty_res, [39:35] count
   output logic [spq_pkg::RSP_TUSER_W-1:0]   rsp_tuser   // [0] out_valid, [2:1] status
);

   spq_pkg::cmd_type cmd;

   spq_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   spq_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

   // A result is written only into a free or draining response register.
   assert property (@(posedge clock) disable iff (reset)
      cmd.exec |-> (!rsp_tvalid || rsp_tready))
      else $error("response overwritten before it was taken");

   // The count never exceeds the queue depth.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[39:35] <= 5'(spq_pkg::DEPTH)))
      else $error("count beyond depth");

   // A refused enqueue only happens on a full queue.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tuser[2:1] == spq_pkg::STAT_FULL)
      |-> (rsp_tdata[39:35] == 5'(spq_pkg::DEPTH)))
      else $error("full status with room left");

   // Empty flag agrees with the count, and a returned entry means success.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> ((rsp_tdata[34] == (rsp_tdata[39:35] == 5'd0)) &&
                      (!rsp_tuser[0] || rsp_tuser[2:1] == spq_pkg::STAT_DONE)))
      else $error("inconsistent response flags");

endmodule

### sim/spq_tb_pkg.sv
// Scoreboard for the stable priority queue testbench: a sorted-slot predictor
// and the queue of responses it expects. Depends on spq_pkg.
`timescale 1ns / 100ps

package spq_tb_pkg;
   import spq_pkg::*;

   typedef struct {
      logic              valid;
      logic [PRIO_W-1:0] prio;
      logic [ID_W-1:0]   id;
      status_type        status;
      logic              empty;
      logic [CNT_W-1:0]  count;
   } queue_response_type;

   class queue_scoreboard;
      logic [PRIO_W-1:0] slot_prio [DEPTH];
      logic [ID_W-1:0]   slot_id [DEPTH];
      int                fill;
      queue_response_type pending_responses [$];
      int                error_count;

      function new();
         fill = 0;
         error_count = 0;
      endfunction

      function int responses_outstanding();
         return pending_responses.size();
      endfunction

      // Applies one accepted request to the predicted queue and records the
      // response it must produce.
      function void note_request(logic op, logic [PRIO_W-1:0] prio_in,
                                 logic [ID_W-1:0] id_in);
         queue_response_type res;
         logic [PRIO_W-1:0] prio;
         int pos;
         res.valid = 1'b0;
         res.prio = '0;
         res.id = '0;
         res.status = STAT_DONE;
         if (op == OP_ENQUEUE) begin
            if (fill >= DEPTH) begin
               res.status = STAT_FULL;
            end else begin
               prio = (prio_in >= PRIO_LEVELS) ? PRIO_W'(PRIO_LEVELS - 1) : prio_in;
               // The new entry goes behind every entry of equal or more urgent
               // priority, which keeps equal priorities in arrival order.
               pos = 0;
               while (pos < fill && slot_prio[pos] <= prio) pos++;
               for (int k = fill; k > pos; k--) begin
                  slot_prio[k] = slot_prio[k-1];
                  slot_id[k] = slot_id[k-1];
               end
               slot_prio[pos] = prio;
               slot_id[pos] = id_in;
               fill++;
            end
         end else begin
            if (fill == 0) begin
               res.status = STAT_EMPTY;
            end else begin
               res.valid = 1'b1;
               res.prio = slot_prio[0];
               res.id = slot_id[0];
               for (int k = 1; k < fill; k++) begin
                  slot_prio[k-1] = slot_prio[k];
                  slot_id[k-1] = slot_id[k];
               end
               fill--;
            end
         end
         res.empty = (fill == 0);
         res.count = CNT_W'(fill);
         pending_responses.push_back(res);
      endfunction

      function void compare_field(string name, longint unsigned expected_value,
                                  longint unsigned actual_value);
         if (expected_value != actual_value) begin
            $error("%s mismatch: expected 0x%0h, got 0x%0h", name, expected_value,
                   actual_value);
            error_count++;
         end
      endfunction

      function void check_response(logic [RSP_TDATA_W-1:0] tdata,
                                   logic [RSP_TUSER_W-1:0] tuser);
         queue_response_type exp;
         if (pending_responses.size() == 0) begin
            $error("response with no request waiting: tdata 0x%0h, tuser 0x%0h",
                   tdata, tuser);
            error_count++;
            return;
         end
         exp = pending_responses.pop_front();
         compare_field("out_valid", exp.valid, tuser[0]);
         compare_field("status", exp.status, tuser[2:1]);
         compare_field("out_priority", exp.prio, tdata[2:0]);
         compare_field("out_id", exp.id, tdata[33:3]);
         compare_field("empty_res", exp.empty, tdata[34]);
         compare_field("count", exp.count, tdata[39:35]);
      endfunction
   endclass

endpackage

### sim/testbench.sv
// Testbench for stable_priority_queue: directed and random enqueue/dequeue
// traffic under varying back-pressure. Depends on spq_pkg and spq_tb_pkg.
`timescale 1ns / 100ps

module testbench;
   import spq_pkg::*;
   import spq_tb_pkg::*;

   localparam int CYCLE_LIMIT = 200000;

   logic                    clock;
   logic                    reset;
   logic                    req_tvalid;
   logic                    req_tready;
   logic [REQ_TDATA_W-1:0]  req_tdata;
   logic                    req_tuser;
   logic                    rsp_tvalid;
   logic                    rsp_tready;
   logic [RSP_TDATA_W-1:0]  rsp_tdata;
   logic [RSP_TUSER_W-1:0]  rsp_tuser;

   int              sender_idle_pct;
   int              receiver_stall_pct;
   int              rsp_hold_cycles;
   int unsigned     cycle_count;
   queue_scoreboard board;

   stable_priority_queue DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // Offers one request, with a random idle gap first, and returns at the
   // edge where it is accepted. Valid stays high into the next request.
   task automatic send_request(input logic op, input logic [PRIO_W-1:0] prio,
                               input logic [ID_W-1:0] id);
      if ($urandom_range(99) < sender_idle_pct) begin
         req_tvalid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_tvalid <= 1'b1;
      req_tuser <= op;
      req_tdata <= {{(REQ_TDATA_W - ID_W - PRIO_W){1'b0}}, id, prio};
      do @(posedge clock); while (!req_tready);
      board.note_request(op, prio, id);
   endtask

   task automatic wait_for_drain();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (board.responses_outstanding() != 0);
   endtask

   // Random traffic in runs that lean toward filling, draining or neither,
   // so the queue passes through full and empty many times.
   task automatic run_random(input int n_items);
      int enqueue_pct;
      int run_left;
      logic op;
      logic [PRIO_W-1:0] prio;
      run_left = 0;
      enqueue_pct = 50;
      for (int i = 0; i < n_items; i++) begin
         if (run_left == 0) begin
            run_left = $urandom_range(60, 15);
            case ($urandom_range(2))
               0: begin
                  enqueue_pct = 80;
               end
               1: begin
                  enqueue_pct = 20;
               end
               default: begin
                  enqueue_pct = 50;
               end
            endcase
         end
         run_left--;
         op = ($urandom_range(99) < enqueue_pct) ? OP_ENQUEUE : OP_DEQUEUE;
         prio = ($urandom_range(99) < 85) ? PRIO_W'($urandom_range(PRIO_LEVELS - 1))
                                          : PRIO_W'($urandom_range(7, PRIO_LEVELS));
         send_request(op, prio, ID_W'($urandom));
      end
   endtask

   // Response side: checks every accepted response and drives ready.
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready) begin
            board.check_response(rsp_tdata, rsp_tuser);
         end
         if (rsp_hold_cycles > 0) begin
            rsp_hold_cycles--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= ($urandom_range(99) >= receiver_stall_pct);
         end
      end
   end

   initial begin
      cycle_count = 0;
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("*** FAILED ***");
      $finish;
   end

   initial begin
      board = new();
      clock = 1'b0;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = OP_ENQUEUE;
      sender_idle_pct = 0;
      receiver_stall_pct = 0;
      rsp_hold_cycles = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty dequeue, ties, an insert ahead of the head, saturated
      // priorities and extreme identifiers, then a fill past capacity.
      send_request(OP_DEQUEUE, 3'd0, '0);
      send_request(OP_ENQUEUE, 3'd2, 31'h5555_5555);
      send_request(OP_ENQUEUE, 3'd2, 31'h2AAA_AAAA);
      send_request(OP_ENQUEUE, 3'd0, 31'h7FFF_FFFF);
      send_request(OP_ENQUEUE, 3'd7, 31'h0000_0000);
      send_request(OP_ENQUEUE, 3'd5, 31'h1234_5678);
      repeat (6) send_request(OP_DEQUEUE, 3'd7, 31'h7FFF_FFFF);
      for (int i = 0; i <= DEPTH; i++) begin
         send_request(OP_ENQUEUE, PRIO_W'(i % 8), ID_W'(i * 32'h0111_1111));
      end

      run_random(350);
      // Long receiver hold-off while requests keep coming, so the block backs up.
      rsp_hold_cycles = 150;
      run_random(100);
      wait_for_drain();

      sender_idle_pct = 71;
      run_random(450);

      sender_idle_pct = 0;
      receiver_stall_pct = 71;
      run_random(450);

      sender_idle_pct = 35;
      receiver_stall_pct = 35;
      run_random(220);
      wait_for_drain();
      run_random(230);

      wait_for_drain();
      repeat (16) @(posedge clock);
      if (board.error_count == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### sim.f
rtl/spq_pkg.sv
rtl/spq_ctrl.sv
rtl/spq_datapath.sv
rtl/stable_priority_queue.sv
sim/spq_tb_pkg.sv
sim/testbench.sv
